/* sv/segment_window_crossing_macros.svh */
// assertion macros for the segment window crossing block
`ifndef SEGMENT_WINDOW_CROSSING_MACROS_SVH
`define SEGMENT_WINDOW_CROSSING_MACROS_SVH

// plain property checked on every clock out of reset
`define SWC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same-cycle implication checked on every clock out of reset
`define SWC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/swc_pkg.sv */
// shared types and constants of the segment window crossing block
`timescale 1ns / 1ps
`default_nettype none
package swc_pkg;
    localparam int IN_W        = 20;
    localparam int REG_W       = 11;
    localparam int COORD_W     = 19;
    localparam int PERIM_W     = 21;
    localparam int NEDGE       = 4;
    localparam int N_W         = 20;
    localparam int DIFF_W      = 21;
    localparam int PROD_W      = 42;
    localparam int NUM_W       = 43;
    localparam int CROSS_W     = 40;
    localparam int QW          = 21;
    localparam int DEN_W       = 21;
    localparam int MAG_W       = DEN_W + QW;
    localparam int QS_W        = QW + 1;
    localparam int DIV_STEPS   = 3;
    localparam int DIV_STG     = QW / DIV_STEPS;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_TUSER_W = 3;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 1'd1;
    localparam logic [REG_W-1:0] WIDTH_RST  = 11'd639;
    localparam logic [REG_W-1:0] HEIGHT_RST = 11'd399;

    typedef enum logic [1:0] {
        EDGE_LEFT   = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_BOTTOM = 2'd2,
        EDGE_TOP    = 2'd3
    } t_edge;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } t_div_in;

    typedef struct packed {
        logic          neg;
        logic          rem_nz;
        logic [QW-1:0] quo;
    } t_div_out;

    typedef struct packed {
        logic [NEDGE-1:0]                st;
        logic [NEDGE-1:0][IN_W-1:0]      ao;
        logic [NEDGE-1:0][NEDGE-1:0]     lt;
    } t_side;
endpackage
`default_nettype wire

/* sv/swc_div.sv */
// pipelined restoring divider, a few quotient bits per stage
`timescale 1ns / 1ps
`default_nettype none
module swc_div (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire swc_pkg::t_div_in  i_d,
    output swc_pkg::t_div_out      o_q
);
    import swc_pkg::*;

    logic [DEN_W-1:0] r_rem [DIV_STG];
    logic [QW-1:0]    r_low [DIV_STG];
    logic [QW-1:0]    r_quo [DIV_STG];
    logic [DEN_W-1:0] r_den [DIV_STG];
    logic             r_neg [DIV_STG];
    logic [DEN_W-1:0] n_rem [DIV_STG];
    logic [QW-1:0]    n_low [DIV_STG];
    logic [QW-1:0]    n_quo [DIV_STG];

    always_comb begin
        logic [DEN_W-1:0] rem;
        logic [QW-1:0]    low;
        logic [QW-1:0]    quo;
        logic [DEN_W-1:0] den;
        logic [DEN_W:0]   trial;
        for (int k = 0; k < DIV_STG; k++) begin
            if (k == 0) begin
                rem = i_d.mag[MAG_W-1:QW];
                low = i_d.mag[QW-1:0];
                quo = '0;
                den = i_d.den;
            end else begin
                rem = r_rem[k-1];
                low = r_low[k-1];
                quo = r_quo[k-1];
                den = r_den[k-1];
            end
            for (int s = 0; s < DIV_STEPS; s++) begin
                trial = {rem, low[QW-1]};
                low   = {low[QW-2:0], 1'b0};
                if (trial >= {1'b0, den}) begin
                    trial = trial - {1'b0, den};
                    quo   = {quo[QW-2:0], 1'b1};
                end else begin
                    quo   = {quo[QW-2:0], 1'b0};
                end
                rem = trial[DEN_W-1:0];
            end
            n_rem[k] = rem;
            n_low[k] = low;
            n_quo[k] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STG; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_quo[k] <= n_quo[k];
                if (k == 0) begin
                    r_den[k] <= i_d.den;
                    r_neg[k] <= i_d.neg;
                end else begin
                    r_den[k] <= r_den[k-1];
                    r_neg[k] <= r_neg[k-1];
                end
            end
        end
    end

    assign o_q.neg    = r_neg[DIV_STG-1];
    assign o_q.rem_nz = |r_rem[DIV_STG-1];
    assign o_q.quo    = r_quo[DIV_STG-1];
endmodule
`default_nettype wire

/* sv/segment_window_crossing.sv */
// top level: segment to clip window border crossing pipeline
//
//  channel  | dir | handshake          | words
//  s        | in  | i_s_tvalid/o_s_tready | segment endpoints
//  m        | out | o_m_tvalid/i_m_tready | crossing result
//  cfg      | in  | i_cfg_wr_en        | window width / height
//
// one word per cycle sustained while the output is not stalled
// the divider has 7 stages (3 quotient bits per stage)
// reset clears the valid bits and loads the default window
// a stall at the output freezes all stages together; nothing is dropped
`timescale 1ns / 1ps
`default_nettype none
`include "segment_window_crossing_macros.svh"
module segment_window_crossing #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [swc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [swc_pkg::REG_W-1:0]         i_cfg_wdata,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // start_x, start_y, end_x, end_y
    input  wire logic [swc_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // cross_x, cross_y, perimeter_pos, zero pad
    output logic [swc_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    // found, edge_hit
    output logic [swc_pkg::OUT_TUSER_W-1:0]        o_m_tuser
);
    import swc_pkg::*;

    localparam int LINE_W = REG_W + FRAC_BITS;
    localparam int CMPW   = ((LINE_W > QS_W + 1) ? LINE_W : QS_W + 1) + 2;
    localparam int WIDE   = ((LINE_W + 3 > PERIM_W) ? LINE_W + 3 : PERIM_W);
    localparam int VLEN   = 3 + DIV_STG + 4;

    logic [REG_W-1:0]  r_width;
    logic [REG_W-1:0]  r_height;
    logic [WIDE-1:0]   r_wh2;
    logic [WIDE-1:0]   r_w2h2;
    logic [VLEN-1:0]   r_v;
    logic              en;

    logic [LINE_W-1:0]      w_fix;
    logic [LINE_W-1:0]      h_fix;
    logic signed [CMPW-1:0] line_v [NEDGE];
    logic signed [CMPW-1:0] len_v  [NEDGE];
    logic signed [CMPW-1:0] am     [NEDGE];
    logic signed [CMPW-1:0] bm     [NEDGE];
    logic [IN_W-1:0]        ao     [NEDGE];
    logic [IN_W-1:0]        bo     [NEDGE];
    logic signed [CMPW-1:0] dif_la [NEDGE];
    logic signed [CMPW-1:0] dif_al [NEDGE];
    logic signed [CMPW-1:0] dif_ba [NEDGE];
    logic signed [CMPW-1:0] dif_ab [NEDGE];

    logic [NEDGE-1:0]       n_st;
    logic [N_W-1:0]         n_n  [NEDGE];
    logic [N_W-1:0]         n_d  [NEDGE];
    logic signed [DIFF_W-1:0] n_df [NEDGE];

    logic [NEDGE-1:0]         r1_st;
    logic [N_W-1:0]           r1_n  [NEDGE];
    logic [N_W-1:0]           r1_d  [NEDGE];
    logic signed [DIFF_W-1:0] r1_df [NEDGE];
    logic [IN_W-1:0]          r1_ao [NEDGE];

    logic [NEDGE-1:0]         r2_st;
    logic signed [PROD_W-1:0] r2_prod [NEDGE];
    logic [CROSS_W-1:0]       r2_x  [NEDGE][NEDGE];
    logic [N_W-1:0]           r2_d  [NEDGE];
    logic [IN_W-1:0]          r2_ao [NEDGE];

    logic signed [NUM_W-1:0]  r3_num [NEDGE];
    logic [N_W-1:0]           r3_d   [NEDGE];
    t_side                    r3_side;

    t_div_in                  div_in  [NEDGE];
    t_div_out                 div_out [NEDGE];
    t_side                    r_side  [DIV_STG];

    logic signed [QS_W-1:0]   r5_qs [NEDGE];
    t_side                    r5_side;
    logic signed [CMPW-1:0]   r6_c  [NEDGE];
    t_side                    r6_side;

    logic [NEDGE-1:0]         keep;
    logic [NEDGE-1:0]         win;
    logic                     n7_found;
    t_edge                    n7_edge;
    logic [LINE_W-1:0]        n7_coord;
    logic                     r7_found;
    t_edge                    r7_edge;
    logic [LINE_W-1:0]        r7_coord;

    logic [WIDE-1:0]          n_cx;
    logic [WIDE-1:0]          n_cy;
    logic [WIDE-1:0]          n_per;
    logic                     r_found;
    t_edge                    r_edge;
    logic [COORD_W-1:0]       r_cx;
    logic [COORD_W-1:0]       r_cy;
    logic [PERIM_W-1:0]       r_per;

    assign en         = !r_v[VLEN-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_v[VLEN-1];
    assign o_m_tdata  = {{(OUT_TDATA_W - 2*COORD_W - PERIM_W){1'b0}}, r_per, r_cy, r_cx};
    assign o_m_tuser  = {r_edge, r_found};

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_WIDTH:  r_width  <= i_cfg_wdata;
                REG_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_fix = {r_width, {FRAC_BITS{1'b0}}};
    assign h_fix = {r_height, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        r_wh2  <= WIDE'(w_fix) + WIDE'({h_fix, 1'b0});
        r_w2h2 <= WIDE'({w_fix, 1'b0}) + WIDE'({h_fix, 1'b0});
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[VLEN-2:0], i_s_tvalid};
        end
    end

    // stage 1: straddle test, t numerator and denominator
    always_comb begin
        am[0] = CMPW'($signed(i_s_tdata[IN_W-1:0]));
        am[1] = am[0];
        bm[0] = CMPW'($signed(i_s_tdata[3*IN_W-1:2*IN_W]));
        bm[1] = bm[0];
        am[2] = CMPW'($signed(i_s_tdata[2*IN_W-1:IN_W]));
        am[3] = am[2];
        bm[2] = CMPW'($signed(i_s_tdata[4*IN_W-1:3*IN_W]));
        bm[3] = bm[2];
        ao[0] = i_s_tdata[2*IN_W-1:IN_W];
        ao[1] = ao[0];
        bo[0] = i_s_tdata[4*IN_W-1:3*IN_W];
        bo[1] = bo[0];
        ao[2] = i_s_tdata[IN_W-1:0];
        ao[3] = ao[2];
        bo[2] = i_s_tdata[3*IN_W-1:2*IN_W];
        bo[3] = bo[2];
        line_v[0] = '0;
        line_v[1] = $signed(CMPW'(w_fix));
        line_v[2] = '0;
        line_v[3] = $signed(CMPW'(h_fix));
        len_v[0]  = $signed(CMPW'(h_fix));
        len_v[1]  = len_v[0];
        len_v[2]  = $signed(CMPW'(w_fix));
        len_v[3]  = len_v[2];
        for (int e = 0; e < NEDGE; e++) begin
            dif_la[e] = line_v[e] - am[e];
            dif_al[e] = am[e] - line_v[e];
            dif_ba[e] = bm[e] - am[e];
            dif_ab[e] = am[e] - bm[e];
            n_st[e] = ((am[e] < line_v[e]) && (bm[e] > line_v[e])) ||
                      ((am[e] > line_v[e]) && (bm[e] < line_v[e]));
            n_n[e]  = (am[e] < line_v[e]) ? dif_la[e][N_W-1:0] : dif_al[e][N_W-1:0];
            n_d[e]  = (am[e] < line_v[e]) ? dif_ba[e][N_W-1:0] : dif_ab[e][N_W-1:0];
            n_df[e] = $signed({bo[e][IN_W-1], bo[e]}) - $signed({ao[e][IN_W-1], ao[e]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_st <= n_st;
            for (int e = 0; e < NEDGE; e++) begin
                r1_n[e]  <= n_n[e];
                r1_d[e]  <= n_d[e];
                r1_df[e] <= n_df[e];
                r1_ao[e] <= ao[e];
            end
        end
    end

    // stage 2: products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_st <= r1_st;
            for (int e = 0; e < NEDGE; e++) begin
                r2_prod[e] <= r1_df[e] * $signed({1'b0, r1_n[e]});
                r2_d[e]    <= r1_d[e];
                r2_ao[e]   <= r1_ao[e];
                for (int j = 0; j < NEDGE; j++) begin
                    r2_x[e][j] <= r1_n[e] * r1_d[j];
                end
            end
        end
    end

    // stage 3: rounding numerator and t ordering
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_side.st <= r2_st;
            for (int e = 0; e < NEDGE; e++) begin
                r3_num[e] <= $signed({r2_prod[e], 1'b0}) +
                             $signed({{(NUM_W-N_W){1'b0}}, r2_d[e]});
                r3_d[e]   <= r2_d[e];
                r3_side.ao[e] <= r2_ao[e];
                for (int j = 0; j < NEDGE; j++) begin
                    r3_side.lt[e][j] <= r2_x[e][j] < r2_x[j][e];
                end
            end
        end
    end

    // divider lanes, one per edge
    always_comb begin
        logic signed [NUM_W-1:0] mag_neg [NEDGE];
        for (int e = 0; e < NEDGE; e++) begin
            mag_neg[e]    = -r3_num[e];
            div_in[e].neg = r3_num[e][NUM_W-1];
            div_in[e].mag = r3_num[e][NUM_W-1] ? mag_neg[e][MAG_W-1:0]
                                               : r3_num[e][MAG_W-1:0];
            div_in[e].den = {r3_d[e], 1'b0};
        end
    end

    for (genvar g = 0; g < NEDGE; g++) begin : g_div
        swc_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (div_in[g]),
            .o_q   (div_out[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < DIV_STG; k++) begin
                if (k == 0) begin
                    r_side[k] <= r3_side;
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    // stage 5: signed floor quotient
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_side <= r_side[DIV_STG-1];
            for (int e = 0; e < NEDGE; e++) begin
                if (div_out[e].neg) begin
                    r5_qs[e] <= $signed(~{1'b0, div_out[e].quo}) +
                                $signed(QS_W'(!div_out[e].rem_nz));
                end else begin
                    r5_qs[e] <= $signed({1'b0, div_out[e].quo});
                end
            end
        end
    end

    // stage 6: crossing coordinate
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_side <= r5_side;
            for (int e = 0; e < NEDGE; e++) begin
                r6_c[e] <= CMPW'($signed(r5_side.ao[e])) + CMPW'(r5_qs[e]);
            end
        end
    end

    // stage 7: keep test and earliest crossing
    always_comb begin
        for (int e = 0; e < NEDGE; e++) begin
            keep[e] = r6_side.st[e] && (r6_c[e] > 0) && (r6_c[e] < len_v[e]);
        end
        for (int e = 0; e < NEDGE; e++) begin
            win[e] = keep[e];
            for (int j = 0; j < NEDGE; j++) begin
                if (j < e) begin
                    win[e] = win[e] && (!keep[j] || r6_side.lt[e][j]);
                end else if (j > e) begin
                    win[e] = win[e] && (!keep[j] || !r6_side.lt[j][e]);
                end
            end
        end
        n7_found = |keep;
        n7_edge  = EDGE_LEFT;
        n7_coord = '0;
        for (int e = 0; e < NEDGE; e++) begin
            if (win[e]) begin
                n7_edge  = t_edge'(2'(e));
                n7_coord = r6_c[e][LINE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_found <= n7_found;
            r7_edge  <= n7_edge;
            r7_coord <= n7_coord;
        end
    end

    // stage 8: point and border position
    always_comb begin
        n_cx  = '0;
        n_cy  = '0;
        n_per = '0;
        if (r7_found) begin
            case (r7_edge)
                EDGE_LEFT: begin
                    n_cy  = WIDE'(r7_coord);
                    n_per = WIDE'(r7_coord);
                end
                EDGE_RIGHT: begin
                    n_cx  = WIDE'(w_fix);
                    n_cy  = WIDE'(r7_coord);
                    n_per = r_wh2 - WIDE'(r7_coord);
                end
                EDGE_BOTTOM: begin
                    n_cx  = WIDE'(r7_coord);
                    n_per = r_w2h2 - WIDE'(r7_coord);
                end
                EDGE_TOP: begin
                    n_cx  = WIDE'(r7_coord);
                    n_cy  = WIDE'(h_fix);
                    n_per = WIDE'(h_fix) + WIDE'(r7_coord);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_found <= r7_found;
            r_edge  <= r7_found ? r7_edge : EDGE_LEFT;
            r_cx    <= n_cx[COORD_W-1:0];
            r_cy    <= n_cy[COORD_W-1:0];
            r_per   <= n_per[PERIM_W-1:0];
        end
    end

    `SWC_ASSERT_IMPL(a_nf_zero, o_m_tvalid && !r_found, (r_cx == '0) && (r_cy == '0) && (r_per == '0) && (r_edge == EDGE_LEFT), "no crossing but fields not zero")
    `SWC_ASSERT_IMPL(a_stall, o_m_tvalid && !i_m_tready, !o_s_tready, "input taken while output stalled")
    `SWC_ASSERT_IMPL(a_left_x, o_m_tvalid && r_found && (r_edge == EDGE_LEFT), r_cx == '0, "left edge crossing with nonzero x")
endmodule
`default_nettype wire

/* tb/testbench.sv */
// scoreboard testbench for the segment window crossing block
`timescale 1ns / 1ps
`default_nettype none

class crossing_board;
    typedef struct {
        logic        found;
        logic [18:0] cx;
        logic [18:0] cy;
        logic [1:0]  edg;
        logic [20:0] per;
    } t_crossing;

    t_crossing pending[$];
    int        mismatches;
    longint    wid;
    longint    hgt;

    function new();
        mismatches = 0;
        wid = 639;
        hgt = 399;
    endfunction

    function longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q -= 1;
        return q;
    endfunction

    function void try_edge(longint am, longint bm, longint ao, longint bo, longint line,
                           longint len, logic [1:0] e, ref logic hit, ref longint tn,
                           ref longint td, ref longint crd, ref logic [1:0] be);
        longint n, d, c;
        if (!((am < line && bm > line) || (am > line && bm < line))) return;
        n = line - am;
        d = bm - am;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        c = fdiv(2 * (ao * d + (bo - ao) * n) + d, 2 * d);
        if (!(c > 0 && c < len)) return;
        if (hit && !(n * td < tn * d)) return;
        hit = 1;
        tn = n;
        td = d;
        crd = c;
        be = e;
    endfunction

    function void note_segment(logic [79:0] seg);
        longint ax, ay, bx, by, w, h, tn, td, crd, cx, cy, per;
        logic hit;
        logic [1:0] be;
        t_crossing r;
        ax = longint'($signed(seg[19:0]));
        ay = longint'($signed(seg[39:20]));
        bx = longint'($signed(seg[59:40]));
        by = longint'($signed(seg[79:60]));
        w = wid << 8;
        h = hgt << 8;
        hit = 0; tn = 0; td = 1; crd = 0; be = swc_pkg::EDGE_LEFT;
        try_edge(ax, bx, ay, by, 0, h, swc_pkg::EDGE_LEFT, hit, tn, td, crd, be);
        try_edge(ax, bx, ay, by, w, h, swc_pkg::EDGE_RIGHT, hit, tn, td, crd, be);
        try_edge(ay, by, ax, bx, 0, w, swc_pkg::EDGE_BOTTOM, hit, tn, td, crd, be);
        try_edge(ay, by, ax, bx, h, w, swc_pkg::EDGE_TOP, hit, tn, td, crd, be);
        cx = 0; cy = 0; per = 0;
        if (hit) begin
            case (be)
                swc_pkg::EDGE_LEFT: begin cy = crd; per = cy; end
                swc_pkg::EDGE_RIGHT: begin cx = w; cy = crd; per = w + 2 * h - cy; end
                swc_pkg::EDGE_BOTTOM: begin cx = crd; per = 2 * w + 2 * h - cx; end
                default: begin cx = crd; cy = h; per = h + cx; end
            endcase
        end
        else be = swc_pkg::EDGE_LEFT;
        r.found = hit;
        r.cx = cx[18:0];
        r.cy = cy[18:0];
        r.edg = be;
        r.per = per[20:0];
        pending.insert(pending.size(), r);
    endfunction

    function void check_crossing(logic [63:0] d, logic [2:0] u);
        t_crossing e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h %h", d, u);
            return;
        end
        e = pending.pop_front();
        if (e.found !== u[0] || e.edg !== u[2:1] || e.cx !== d[18:0] ||
            e.cy !== d[37:19] || e.per !== d[58:38] || d[63:59] !== 5'd0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp f=%b e=%0d x=%h y=%h p=%h got f=%b e=%0d x=%h y=%h p=%h",
                         e.found, e.edg, e.cx, e.cy, e.per, u[0], u[2:1], d[18:0],
                         d[37:19], d[58:38]);
        end
    endfunction
endclass

module testbench;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_wr_en = 0;
    logic [0:0]  i_cfg_addr = '0;
    logic [10:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [79:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [63:0] o_m_tdata;
    logic [2:0]  o_m_tuser;

    crossing_board board = new();
    int  cycles = 0;
    bit  calm = 0;
    bit  long_hold = 0;

    segment_window_crossing i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_crossing(o_m_tdata, o_m_tuser);

    initial begin : sink
        int k;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_m_tready <= 0;
                repeat (60) @(posedge i_clk);
                long_hold = 0;
            end
            else if (!calm && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 0;
                k = $urandom_range(1, 4);
                repeat (k) @(posedge i_clk);
            end
            else begin
                i_m_tready <= 1;
                @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [10:0] val);
        i_cfg_wr_en <= 1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == swc_pkg::REG_WIDTH) board.wid = longint'(val);
        else board.hgt = longint'(val);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_segment(logic [79:0] seg);
        int k;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 0;
            k = $urandom_range(1, 4);
            repeat (k) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= seg;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_segment(seg);
    endtask

    function automatic logic [19:0] pick_coord(longint lim);
        longint v;
        case ($urandom_range(0, 5))
            0: v = longint'($signed(20'($urandom)));
            1: v = 0;
            2: v = lim;
            3: v = $urandom_range(0, 3) == 0 ? -524288 : 524287;
            default: v = longint'($urandom_range(0, lim + 512)) - 256;
        endcase
        return v[19:0];
    endfunction

    function automatic logic [79:0] rand_segment();
        longint w, h;
        w = board.wid << 8;
        h = board.hgt << 8;
        return {pick_coord(h), pick_coord(w), pick_coord(h), pick_coord(w)};
    endfunction

    function automatic logic [79:0] seg_of(int ax, int ay, int bx, int by);
        logic [19:0] a, b, c, d;
        a = ax[19:0]; b = ay[19:0]; c = bx[19:0]; d = by[19:0];
        return {d, c, b, a};
    endfunction

    initial begin
        logic [10:0] wv[6];
        logic [10:0] hv[6];
        int k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed, default window 639 x 399
        send_segment(seg_of(-256, 1000, 1000, 1000));
        send_segment(seg_of(1000, 1000, 200000, 1000));
        send_segment(seg_of(1000, -256, 1000, 1000));
        send_segment(seg_of(1000, 1000, 1000, 200000));
        send_segment(seg_of(-512, -512, 512, 512));
        send_segment(seg_of(0, 1000, 2000, 1000));
        send_segment(seg_of(-1000, 500, -1000, 600));
        send_segment(seg_of(-524288, -524288, 524287, 524287));
        send_segment(seg_of(524287, 524287, -524288, -524288));
        send_segment(seg_of(-256, 1000, 200000, 50000));
        send_segment(seg_of(-100, -100, 100, 100));
        send_segment(seg_of(10, 10, 20, 20));
        send_segment(seg_of(-1, 0, 3, 3));
        drain();
        wv = '{11'd1, 11'd2047, 11'd0, 11'd640, 11'd3, 11'd639};
        hv = '{11'd2047, 11'd1, 11'd5, 11'd0, 11'd480, 11'd399};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(swc_pkg::REG_WIDTH, wv[ph]);
            write_reg(swc_pkg::REG_HEIGHT, hv[ph]);
            i_cfg_wr_en <= 0;
            if (ph == 5) calm = 1;
            for (int n = 0; n < 240; n++) begin
                if (ph == 1 && n == 30) long_hold = 1;
                if (ph == 2 && n == 100) begin
                    i_s_tvalid <= 0;
                    while (board.pending.size() != 0) @(posedge i_clk);
                end
                send_segment(rand_segment());
            end
            drain();
        end
        k = 0;
        while (board.pending.size() != 0 && k < 5000) begin
            @(posedge i_clk);
            k++;
        end
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("status: pass");
        end
        else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* segment_window_crossing.f */
+incdir+sv
sv/swc_pkg.sv
sv/swc_div.sv
sv/segment_window_crossing.sv
tb/testbench.sv
